// ===== rtl/core/bezier_segment_split_top_assert.svh =====
// Assertion macros for the segment splitter.
// BSS_ASSERT_IMPL checks cons in the same cycle as ante.
// BSS_ASSERT_NEXT checks cons in the cycle after ante.
`ifndef BEZIER_SEGMENT_SPLIT_TOP_ASSERT_SVH
`define BEZIER_SEGMENT_SPLIT_TOP_ASSERT_SVH
`ifndef SYNTH
`define BSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment splitter assertion failed");
`define BSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment splitter assertion failed");
`else
`define BSS_ASSERT_IMPL(label, ante, cons)
`define BSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/bss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  // Q16.16 coordinate word
  typedef logic signed [31:0] coord_t;

  // Input segment kinds
  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_QUAD  = 2'd1;
  localparam logic [1:0] KIND_CUBIC = 2'd2;

  // Result segment kinds
  localparam logic HALF_LINE  = 1'b0;
  localparam logic HALF_CUBIC = 1'b1;

  // Segment as a cubic; index 0 is x, index 1 is y
  typedef struct packed {
    logic         is_line;
    coord_t [1:0] p0;
    coord_t [1:0] p1;
    coord_t [1:0] p2;
    coord_t [1:0] p3;
  } seg_t;

  // Latency of one interpolation unit
  localparam int LERP_LAT = 3;
  localparam int PIPE_LEN = 3 * LERP_LAT;

  // Rounded divide by three: floor(m * DIV3_MUL / 2^DIV3_SHIFT), m below 2^34
  localparam int DIV3_W     = 34;
  localparam int DIV3_SPLIT = 17;
  localparam int DIV3_MUL_W = 34;
  localparam int DIV3_PP_W  = DIV3_SPLIT + DIV3_MUL_W;
  localparam int DIV3_SUM_W = DIV3_W + DIV3_MUL_W;
  localparam int DIV3_SHIFT = 35;
  localparam longint unsigned DIV3_MUL_L = ((64'd1 << DIV3_SHIFT) + 64'd1) / 64'd3;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = DIV3_MUL_W'(DIV3_MUL_L);

  // Segment queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// ===== rtl/core/bss_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bss_in_if #(
  parameter int TW = 17
);
  logic               valid;
  logic               ready;
  logic [1:0]         curve_kind;
  logic [TW-1:0]      t_param;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] ctrl1_x;
  logic signed [31:0] ctrl1_y;
  logic signed [31:0] ctrl2_x;
  logic signed [31:0] ctrl2_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;

  modport source (
    output valid, curve_kind, t_param, start_x, start_y, ctrl1_x, ctrl1_y,
           ctrl2_x, ctrl2_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, curve_kind, t_param, start_x, start_y, ctrl1_x, ctrl1_y,
           ctrl2_x, ctrl2_y, end_x, end_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/bss_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bss_out_if;
  logic               valid;
  logic               ready;
  logic               half_kind;
  logic               is_last;
  logic signed [31:0] out_start_x;
  logic signed [31:0] out_start_y;
  logic signed [31:0] out_ctrl1_x;
  logic signed [31:0] out_ctrl1_y;
  logic signed [31:0] out_ctrl2_x;
  logic signed [31:0] out_ctrl2_y;
  logic signed [31:0] out_end_x;
  logic signed [31:0] out_end_y;

  modport source (
    output valid, half_kind, is_last, out_start_x, out_start_y, out_ctrl1_x,
           out_ctrl1_y, out_ctrl2_x, out_ctrl2_y, out_end_x, out_end_y,
    input  ready
  );
  modport sink (
    input  valid, half_kind, is_last, out_start_x, out_start_y, out_ctrl1_x,
           out_ctrl1_y, out_ctrl2_x, out_ctrl2_y, out_end_x, out_end_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/bss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bss_front #(
  parameter int TF = 16
) (
  input  logic          clk,
  input  logic          rst,
  bss_in_if.sink        segment,
  output logic          item_valid,
  output bss_pkg::seg_t item_seg,
  output logic [TF:0]   item_t,
  input  logic          item_full
);
  import bss_pkg::*;

  localparam int TW = TF + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << TF;

  logic en;
  logic v1, v2, v3;

  coord_t [1:0] in_p0, in_p1, in_p2, in_p3;
  logic [TW-1:0] t_clamp;

  logic signed [DIV3_W-1:0] sum_c  [2][2];
  logic                     neg_c  [2][2];
  logic [DIV3_W-1:0]        mag_c  [2][2];

  // stage 1: clamped t, quadratic sums
  logic          s1_line, s1_quad;
  logic [TW-1:0] s1_t;
  coord_t [1:0]  s1_p0, s1_p1, s1_p2, s1_p3;
  logic          s1_neg [2][2];
  logic [DIV3_W-1:0] s1_mag [2][2];

  // stage 2: partial products of the reciprocal multiply
  logic          s2_line, s2_quad;
  logic [TW-1:0] s2_t;
  coord_t [1:0]  s2_p0, s2_p1, s2_p2, s2_p3;
  logic          s2_neg [2][2];
  logic [DIV3_PP_W-1:0] s2_pl [2][2];
  logic [DIV3_PP_W-1:0] s2_ph [2][2];

  logic [DIV3_SUM_W-1:0] full_c [2][2];
  logic [32:0]           quo_c  [2][2];
  coord_t [1:0]          rc1_c, rc2_c;

  assign en            = !v3 || !item_full;
  assign segment.ready = en;
  assign item_valid    = v3;

  assign in_p0 = {segment.start_y, segment.start_x};
  assign in_p1 = {segment.ctrl1_y, segment.ctrl1_x};
  assign in_p2 = {segment.ctrl2_y, segment.ctrl2_x};
  assign in_p3 = {segment.end_y, segment.end_x};

  // clamp t to one
  assign t_clamp = (segment.t_param > T_ONE) ? T_ONE : segment.t_param;

  // form p0 + 2q and 2q + p3, take magnitude plus one for rounding
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      sum_c[g][0] = $signed({{2{in_p0[g][31]}}, in_p0[g]})
                  + $signed({in_p1[g][31], in_p1[g], 1'b0});
      sum_c[g][1] = $signed({in_p1[g][31], in_p1[g], 1'b0})
                  + $signed({{2{in_p3[g][31]}}, in_p3[g]});
      for (int w = 0; w < 2; w++) begin
        neg_c[g][w] = sum_c[g][w][DIV3_W-1];
        mag_c[g][w] = (neg_c[g][w] ? DIV3_W'(-sum_c[g][w]) : DIV3_W'(sum_c[g][w]))
                    + DIV3_W'(1);
      end
    end
  end

  // finish the reciprocal multiply and restore the sign
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      for (int w = 0; w < 2; w++) begin
        full_c[g][w] = DIV3_SUM_W'({s2_ph[g][w], {DIV3_SPLIT{1'b0}}})
                     + DIV3_SUM_W'(s2_pl[g][w]);
        quo_c[g][w]  = full_c[g][w][DIV3_SHIFT+32:DIV3_SHIFT];
      end
      rc1_c[g] = s2_neg[g][0] ? coord_t'(-quo_c[g][0]) : coord_t'(quo_c[g][0]);
      rc2_c[g] = s2_neg[g][1] ? coord_t'(-quo_c[g][1]) : coord_t'(quo_c[g][1]);
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= segment.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_line <= (segment.curve_kind == KIND_LINE);
      s1_quad <= (segment.curve_kind == KIND_QUAD);
      s1_t    <= t_clamp;
      s1_p0   <= in_p0;
      s1_p1   <= in_p1;
      s1_p2   <= in_p2;
      s1_p3   <= in_p3;
      s1_neg  <= neg_c;
      s1_mag  <= mag_c;

      s2_line <= s1_line;
      s2_quad <= s1_quad;
      s2_t    <= s1_t;
      s2_p0   <= s1_p0;
      s2_p1   <= s1_p1;
      s2_p2   <= s1_p2;
      s2_p3   <= s1_p3;
      s2_neg  <= s1_neg;
      for (int g = 0; g < 2; g++) begin
        for (int w = 0; w < 2; w++) begin
          s2_pl[g][w] <= DIV3_PP_W'(s1_mag[g][w][DIV3_SPLIT-1:0]) * DIV3_PP_W'(DIV3_MUL);
          s2_ph[g][w] <= DIV3_PP_W'(s1_mag[g][w][DIV3_W-1:DIV3_SPLIT])
                       * DIV3_PP_W'(DIV3_MUL);
        end
      end

      item_seg.is_line <= s2_line;
      item_seg.p0      <= s2_p0;
      item_seg.p1      <= s2_quad ? rc1_c : s2_p1;
      item_seg.p2      <= s2_quad ? rc2_c : s2_p2;
      item_seg.p3      <= s2_p3;
      item_t           <= s2_t;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bss_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bss_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] rdata
);
  import bss_pkg::*;

  logic [W-1:0]      mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rd_ptr];

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bss_lerp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bss_lerp #(
  parameter int TF = 16
) (
  input  logic            clk,
  input  logic            en,
  input  bss_pkg::coord_t a,
  input  bss_pkg::coord_t b,
  input  logic [TF:0]     t,
  output bss_pkg::coord_t res
);
  import bss_pkg::*;

  localparam int TW = TF + 1;
  localparam int PW = 33 + TW;
  localparam logic [PW-1:0] HALF = PW'(1) << (TF - 1);

  logic signed [32:0] diff_c;
  logic               neg_c;
  logic [32:0]        mag_c;
  logic [PW-1:0]      rnd_c;
  logic [31:0]        step_c;

  coord_t        a1, a2;
  logic          neg1, neg2;
  logic [32:0]   mag1;
  logic [TW-1:0] t1;
  logic [PW-1:0] prod2;

  // take b - a apart into sign and magnitude
  assign diff_c = $signed({b[31], b}) - $signed({a[31], a});
  assign neg_c  = diff_c[32];
  assign mag_c  = neg_c ? 33'(-diff_c) : 33'(diff_c);

  // round the scaled step to nearest, ties away from zero
  assign rnd_c  = prod2 + HALF;
  assign step_c = rnd_c[TF+31:TF];

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= a;
      neg1  <= neg_c;
      mag1  <= mag_c;
      t1    <= t;
      a2    <= a1;
      neg2  <= neg1;
      prod2 <= PW'(mag1) * PW'(t1);
      res   <= neg2 ? a2 - coord_t'(step_c) : a2 + coord_t'(step_c);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bss_back #(
  parameter int TF = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  bss_pkg::seg_t item_seg,
  input  logic [TF:0]   item_t,
  output logic          item_pop,
  bss_out_if.source     half
);
  import bss_pkg::*;

  localparam int TW = TF + 1;
  localparam int L1 = LERP_LAT;
  localparam int L2 = 2 * LERP_LAT;

  logic en, load;
  logic [PIPE_LEN:1] vld;

  // passthrough lines along the lerp levels
  coord_t [1:0]  pa    [1:PIPE_LEN];
  coord_t [1:0]  pd    [1:PIPE_LEN];
  logic          pline [1:PIPE_LEN];
  logic [TW-1:0] pt    [1:L2];
  coord_t [1:0]  dab   [L1+1:PIPE_LEN];
  coord_t [1:0]  dcd   [L1+1:PIPE_LEN];
  coord_t [1:0]  dabc  [L2+1:PIPE_LEN];
  coord_t [1:0]  dbcd  [L2+1:PIPE_LEN];

  coord_t ab [2], bc [2], cd [2], abc [2], bcd [2], mid [2];
  coord_t mid_a [2], mid_b [2];

  // result register with both halves
  logic         res_valid, res_half, res_line;
  coord_t [1:0] r_a, r_ab, r_abc, r_mid, r_bcd, r_cd, r_d;
  logic         out_take;

  assign out_take = res_valid && half.ready;
  assign load     = vld[PIPE_LEN] && (!res_valid || (out_take && res_half));
  assign en       = !vld[PIPE_LEN] || load;
  assign item_pop = en && item_valid;

  // three levels of interpolation per axis
  for (genvar g = 0; g < 2; g++) begin : g_axis
    bss_lerp #(.TF(TF)) u_ab (
      .clk(clk), .en(en), .a(item_seg.p0[g]), .b(item_seg.p1[g]), .t(item_t), .res(ab[g])
    );
    bss_lerp #(.TF(TF)) u_bc (
      .clk(clk), .en(en), .a(item_seg.p1[g]), .b(item_seg.p2[g]), .t(item_t), .res(bc[g])
    );
    bss_lerp #(.TF(TF)) u_cd (
      .clk(clk), .en(en), .a(item_seg.p2[g]), .b(item_seg.p3[g]), .t(item_t), .res(cd[g])
    );
    bss_lerp #(.TF(TF)) u_abc (
      .clk(clk), .en(en), .a(ab[g]), .b(bc[g]), .t(pt[L1]), .res(abc[g])
    );
    bss_lerp #(.TF(TF)) u_bcd (
      .clk(clk), .en(en), .a(bc[g]), .b(cd[g]), .t(pt[L1]), .res(bcd[g])
    );

    // a line splits its end points directly
    assign mid_a[g] = pline[L2] ? pa[L2][g] : abc[g];
    assign mid_b[g] = pline[L2] ? pd[L2][g] : bcd[g];

    bss_lerp #(.TF(TF)) u_mid (
      .clk(clk), .en(en), .a(mid_a[g]), .b(mid_b[g]), .t(pt[L2]), .res(mid[g])
    );
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-1:1], item_valid};
    end
  end

  // advance passthrough lines
  always_ff @(posedge clk) begin
    if (en) begin
      pa[1]    <= item_seg.p0;
      pd[1]    <= item_seg.p3;
      pline[1] <= item_seg.is_line;
      pt[1]    <= item_t;
      for (int k = 2; k <= PIPE_LEN; k++) begin
        pa[k]    <= pa[k-1];
        pd[k]    <= pd[k-1];
        pline[k] <= pline[k-1];
      end
      for (int k = 2; k <= L2; k++) begin
        pt[k] <= pt[k-1];
      end
      for (int g = 0; g < 2; g++) begin
        dab[L1+1][g]  <= ab[g];
        dcd[L1+1][g]  <= cd[g];
        dabc[L2+1][g] <= abc[g];
        dbcd[L2+1][g] <= bcd[g];
      end
      for (int k = L1 + 2; k <= PIPE_LEN; k++) begin
        dab[k] <= dab[k-1];
        dcd[k] <= dcd[k-1];
      end
      for (int k = L2 + 2; k <= PIPE_LEN; k++) begin
        dabc[k] <= dabc[k-1];
        dbcd[k] <= dbcd[k-1];
      end
    end
  end

  // hold result control: first half, then second half
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_half  <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
      res_half  <= 1'b0;
    end else if (out_take) begin
      if (res_half) begin
        res_valid <= 1'b0;
      end else begin
        res_half <= 1'b1;
      end
    end
  end

  // capture finished segment
  always_ff @(posedge clk) begin
    if (load) begin
      res_line <= pline[PIPE_LEN];
      r_a      <= pa[PIPE_LEN];
      r_d      <= pd[PIPE_LEN];
      r_ab     <= dab[PIPE_LEN];
      r_cd     <= dcd[PIPE_LEN];
      r_abc    <= dabc[PIPE_LEN];
      r_bcd    <= dbcd[PIPE_LEN];
      r_mid[0] <= mid[0];
      r_mid[1] <= mid[1];
    end
  end

  // drive the current half
  assign half.valid       = res_valid;
  assign half.half_kind   = res_line ? HALF_LINE : HALF_CUBIC;
  assign half.is_last     = res_half;
  assign half.out_start_x = res_half ? r_mid[0] : r_a[0];
  assign half.out_start_y = res_half ? r_mid[1] : r_a[1];
  assign half.out_ctrl1_x = res_line ? '0 : (res_half ? r_bcd[0] : r_ab[0]);
  assign half.out_ctrl1_y = res_line ? '0 : (res_half ? r_bcd[1] : r_ab[1]);
  assign half.out_ctrl2_x = res_line ? '0 : (res_half ? r_cd[0] : r_abc[0]);
  assign half.out_ctrl2_y = res_line ? '0 : (res_half ? r_cd[1] : r_abc[1]);
  assign half.out_end_x   = res_half ? r_d[0] : r_mid[0];
  assign half.out_end_y   = res_half ? r_d[1] : r_mid[1];

endmodule

`default_nettype wire

// ===== rtl/core/bezier_segment_split_top.sv =====
// Segment splitter: cuts a line, quadratic or cubic path segment at t.
// Input channel "segment" carries one segment request (kind, t in
// Q1.T_FRAC_BITS, four Q16.16 points). Output channel "half" returns two
// requests per segment: the first half, then the second with is_last set.
// Lines come back as lines with zero controls; quadratics and cubics come
// back as cubics. Both channels use valid/ready.
// The first half reaches the output once the segment has passed the front,
// the queue and the back; the second half follows in the cycle after the
// first is taken. The front (clamp and quadratic raise) feeds a 2-entry
// queue; the back runs three interpolation levels. The single result
// register hands out two halves per segment and loads the next segment
// only once both halves of the last one are taken.
// A stall on "half" holds the result register, then freezes the back
// pipeline, fills the queue and finally drops segment.ready; no request is
// lost. Synchronous reset empties every stage and the queue.
`timescale 1ns / 1ps
`default_nettype none

`include "bezier_segment_split_top_assert.svh"

module bezier_segment_split_top #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  bss_in_if.sink    segment,
  bss_out_if.source half
);
  import bss_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;
  localparam int QW = $bits(seg_t) + TW;

  logic          f_valid, q_full, q_push, q_pop, q_nonempty;
  seg_t          f_seg, b_seg;
  logic [TW-1:0] f_t, b_t;
  logic [QW-1:0] q_rdata;

  bss_front #(.TF(T_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .segment   (segment),
    .item_valid(f_valid),
    .item_seg  (f_seg),
    .item_t    (f_t),
    .item_full (q_full)
  );

  assign q_push = f_valid && !q_full;

  bss_queue #(.W(QW)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wdata   ({f_seg, f_t}),
    .full    (q_full),
    .pop     (q_pop),
    .nonempty(q_nonempty),
    .rdata   (q_rdata)
  );

  assign b_seg = q_rdata[QW-1:TW];
  assign b_t   = q_rdata[TW-1:0];

  bss_back #(.TF(T_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(q_nonempty),
    .item_seg  (b_seg),
    .item_t    (b_t),
    .item_pop  (q_pop),
    .half      (half)
  );

  // input stalls only when the front's last stage holds an item and the queue cannot take more
  `BSS_ASSERT_IMPL(a_stall_cause, !segment.ready, f_valid && q_full)
  // a taken first half is always followed by its second half
  `BSS_ASSERT_NEXT(a_second_half, half.valid && half.ready && !half.is_last,
                   half.valid && half.is_last)
  // both halves share the split point
  `BSS_ASSERT_NEXT(a_shared_mid, half.valid && half.ready && !half.is_last,
                   half.out_start_x == $past(half.out_end_x) &&
                   half.out_start_y == $past(half.out_end_y))

endmodule

`default_nettype wire

// ===== sim/bezier_segment_split_top_test.sv =====
`timescale 1ns / 1ps

module bezier_segment_split_top_test;
  import bss_pkg::*;

  localparam int              T_FRAC        = 16;
  localparam longint unsigned T_ONE         = 64'd1 << T_FRAC;
  localparam longint unsigned T_ROUND       = 64'd1 << (T_FRAC - 1);
  localparam logic [1:0]      KIND_SPARE    = 2'd3;
  localparam logic [31:0]     COORD_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0]     COORD_MIN     = 32'h8000_0000;
  localparam int              WATCHDOG_MAX  = 2000;
  localparam int              DRAIN_CYCLES  = 24;

  // One segment request; points are start, ctrl1, ctrl2, end with x before y
  typedef struct packed {
    logic [1:0]       kind;
    logic [16:0]      t;
    logic [7:0][31:0] pt;
  } seg_item_t;

  // One half request; same point order as the segment
  typedef struct packed {
    logic             kind;
    logic             last;
    logic [7:0][31:0] pt;
  } half_item_t;

  logic clk = 1'b0;
  logic rst;

  bss_in_if #(.TW(17)) seg_if ();
  bss_out_if           half_if ();

  half_item_t expected_halves [$];
  int         error_count   = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         stalled_cycles = 0;

  bezier_segment_split_top #(
    .T_FRAC_BITS(T_FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .segment(seg_if),
    .half(half_if)
  );

  always #5 clk = ~clk;

  // Interpolate a toward b by t, rounding half away from zero
  function automatic longint interp(input longint a, input longint b,
                                    input longint unsigned t);
    longint          d;
    longint unsigned mag;
    longint unsigned r;
    d   = b - a;
    mag = (d < 0) ? -d : d;
    r   = (mag * t + T_ROUND) >> T_FRAC;
    return (d < 0) ? a - longint'(r) : a + longint'(r);
  endfunction

  // Divide by three, rounding to nearest
  function automatic longint third_round(input longint s);
    longint unsigned mag;
    longint unsigned q;
    mag = (s < 0) ? -s : s;
    q   = (mag + 64'd1) / 64'd3;
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Work out both halves of a segment and queue them in order
  function automatic void split_segment(input seg_item_t seg);
    longint          p [8];
    longint          first [8];
    longint          second [8];
    longint unsigned tc;
    longint          q2, ab, bc, cd, abc, bcd, mid;
    half_item_t      lo;
    half_item_t      hi;
    int              i;
    tc = seg.t;
    if (tc > T_ONE) tc = T_ONE;
    for (i = 0; i < 8; i++) p[i] = $signed(seg.pt[i]);

    if (seg.kind == KIND_LINE) begin
      for (i = 0; i < 2; i++) begin
        mid           = interp(p[i], p[6 + i], tc);
        first[i]      = p[i];
        first[2 + i]  = 0;
        first[4 + i]  = 0;
        first[6 + i]  = mid;
        second[i]     = mid;
        second[2 + i] = 0;
        second[4 + i] = 0;
        second[6 + i] = p[6 + i];
      end
      lo.kind = HALF_LINE;
    end else begin
      // Raise a quadratic to cubic form; its ctrl2 is ignored
      if (seg.kind == KIND_QUAD) begin
        for (i = 0; i < 2; i++) begin
          q2       = p[2 + i] * 2;
          p[2 + i] = third_round(p[i] + q2);
          p[4 + i] = third_round(q2 + p[6 + i]);
        end
      end
      for (i = 0; i < 2; i++) begin
        ab  = interp(p[i], p[2 + i], tc);
        bc  = interp(p[2 + i], p[4 + i], tc);
        cd  = interp(p[4 + i], p[6 + i], tc);
        abc = interp(ab, bc, tc);
        bcd = interp(bc, cd, tc);
        mid = interp(abc, bcd, tc);
        first[i]      = p[i];
        first[2 + i]  = ab;
        first[4 + i]  = abc;
        first[6 + i]  = mid;
        second[i]     = mid;
        second[2 + i] = bcd;
        second[4 + i] = cd;
        second[6 + i] = p[6 + i];
      end
      lo.kind = HALF_CUBIC;
    end

    hi.kind = lo.kind;
    lo.last = 1'b0;
    hi.last = 1'b1;
    for (i = 0; i < 8; i++) begin
      lo.pt[i] = first[i][31:0];
      hi.pt[i] = second[i][31:0];
    end
    expected_halves.push_back(lo);
    expected_halves.push_back(hi);
  endfunction

  function automatic seg_item_t build_seg(input logic [1:0] kind, input logic [16:0] t,
                                          input logic [31:0] sx, input logic [31:0] sy,
                                          input logic [31:0] c1x, input logic [31:0] c1y,
                                          input logic [31:0] c2x, input logic [31:0] c2y,
                                          input logic [31:0] ex, input logic [31:0] ey);
    seg_item_t s;
    s.kind  = kind;
    s.t     = t;
    s.pt[0] = sx;
    s.pt[1] = sy;
    s.pt[2] = c1x;
    s.pt[3] = c1y;
    s.pt[4] = c2x;
    s.pt[5] = c2y;
    s.pt[6] = ex;
    s.pt[7] = ey;
    return s;
  endfunction

  // Pick a coordinate: extremes, small values of either sign, or any word
  function automatic logic [31:0] rand_coord();
    logic [31:0] w;
    int          r;
    r = $urandom_range(0, 7);
    w = $urandom;
    case (r)
      0: begin
        w = COORD_MAX;
      end
      1: begin
        w = COORD_MIN;
      end
      2, 3: begin
        w = {{12{w[19]}}, w[19:0]};
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic seg_item_t rand_seg();
    seg_item_t s;
    int        r;
    int        i;
    r = $urandom_range(0, 15);
    if (r < 5) s.kind = KIND_LINE;
    else if (r < 10) s.kind = KIND_QUAD;
    else if (r < 15) s.kind = KIND_CUBIC;
    else s.kind = KIND_SPARE;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        s.t = 17'd0;
      end
      1: begin
        s.t = 17'(T_ONE);
      end
      2: begin
        s.t = 17'($urandom_range(65537, 131071));
      end
      default: begin
        s.t = 17'($urandom_range(0, 65536));
      end
    endcase
    for (i = 0; i < 8; i++) s.pt[i] = rand_coord();
    return s;
  endfunction

  // Offer one segment request, hold it until taken, then queue its halves
  task automatic send_segment(input seg_item_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(posedge clk);
    end
    seg_if.valid      <= 1'b1;
    seg_if.curve_kind <= s.kind;
    seg_if.t_param    <= s.t;
    seg_if.start_x    <= s.pt[0];
    seg_if.start_y    <= s.pt[1];
    seg_if.ctrl1_x    <= s.pt[2];
    seg_if.ctrl1_y    <= s.pt[3];
    seg_if.ctrl2_x    <= s.pt[4];
    seg_if.ctrl2_y    <= s.pt[5];
    seg_if.end_x      <= s.pt[6];
    seg_if.end_y      <= s.pt[7];
    @(posedge clk);
    while (!seg_if.ready) @(posedge clk);
    split_segment(s);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      error_count++;
    end
  endtask

  // Compare each accepted half request with the oldest expected one
  always @(posedge clk) begin : check_halves
    half_item_t want;
    if (!rst && half_if.valid && half_if.ready) begin
      if (expected_halves.size() == 0) begin
        $error("half request with no segment outstanding");
        error_count++;
      end else begin
        want = expected_halves.pop_front();
        check_field("half_kind", 32'(want.kind), 32'(half_if.half_kind));
        check_field("is_last", 32'(want.last), 32'(half_if.is_last));
        check_field("out_start_x", want.pt[0], half_if.out_start_x);
        check_field("out_start_y", want.pt[1], half_if.out_start_y);
        check_field("out_ctrl1_x", want.pt[2], half_if.out_ctrl1_x);
        check_field("out_ctrl1_y", want.pt[3], half_if.out_ctrl1_y);
        check_field("out_ctrl2_x", want.pt[4], half_if.out_ctrl2_x);
        check_field("out_ctrl2_y", want.pt[5], half_if.out_ctrl2_y);
        check_field("out_end_x", want.pt[6], half_if.out_end_x);
        check_field("out_end_y", want.pt[7], half_if.out_end_y);
      end
    end
    // Stall the result side at random
    half_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (seg_if.valid && seg_if.ready) || (half_if.valid && half_if.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Split at t of zero and one for every kind code, and above one for a cubic and a line
  task automatic test_t_extremes();
    logic [1:0] k;
    int         i;
    for (i = 0; i < 4; i++) begin
      k = 2'(i);
      send_segment(build_seg(k, 17'd0, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord()));
      send_segment(build_seg(k, 17'(T_ONE), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord()));
    end
    send_segment(build_seg(KIND_CUBIC, 17'h1FFFF, rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord()));
    send_segment(build_seg(KIND_LINE, 17'h10001, rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord()));
  endtask

  // Drive points to the ends of the coordinate range, plus one all-zero cubic
  task automatic test_coord_extremes();
    send_segment(build_seg(KIND_LINE, 17'd32768, COORD_MIN, COORD_MIN, COORD_MAX,
                           COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_segment(build_seg(KIND_LINE, 17'd1, COORD_MAX, COORD_MAX, 32'd0, 32'd0,
                           32'd0, 32'd0, COORD_MIN, COORD_MIN));
    send_segment(build_seg(KIND_CUBIC, 17'd65535, COORD_MAX, COORD_MIN, COORD_MIN,
                           COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    send_segment(build_seg(KIND_QUAD, 17'd21845, COORD_MAX, COORD_MAX, COORD_MAX,
                           COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN));
    send_segment(build_seg(KIND_QUAD, 17'd43690, COORD_MIN, COORD_MIN, COORD_MIN,
                           COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
    send_segment(build_seg(KIND_CUBIC, 17'd32768, COORD_MIN, COORD_MIN, COORD_MIN,
                           COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_segment(build_seg(KIND_CUBIC, 17'd12345, 32'd0, 32'd0, 32'd0, 32'd0,
                           32'd0, 32'd0, 32'd0, 32'd0));
  endtask

  // Random segments of every kind with mixed coordinates and t
  task automatic test_random_segments(input int count);
    int n;
    for (n = 0; n < count; n++) send_segment(rand_seg());
  endtask

  initial begin
    rst                <= 1'b1;
    seg_if.valid       <= 1'b0;
    seg_if.curve_kind  <= KIND_LINE;
    seg_if.t_param     <= '0;
    seg_if.start_x     <= '0;
    seg_if.start_y     <= '0;
    seg_if.ctrl1_x     <= '0;
    seg_if.ctrl1_y     <= '0;
    seg_if.ctrl2_x     <= '0;
    seg_if.ctrl2_y     <= '0;
    seg_if.end_x       <= '0;
    seg_if.end_y       <= '0;
    send_idle_pct = 11;
    recv_idle_pct = 74;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_t_extremes();
    test_coord_extremes();
    test_random_segments(200);

    send_idle_pct = 74;
    recv_idle_pct = 11;
    test_random_segments(215);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_segments(215);
    seg_if.valid <= 1'b0;

    // Drain outstanding halves, then let the pipeline settle
    while (expected_halves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_halves.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
